// File: rtl/mqe_pkg.sv
// Shared types, constants and helpers of the quadrature encoder bank.
package mqe_pkg;

    // Field widths
    localparam int KIND_W  = 3;
    localparam int PIN_W   = 4;
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 16;
    localparam int TH_W    = 8;
    localparam int STEP_W  = 2;

    // Default bank size
    localparam int NUM_ENCODERS_DEF = 4;

    // Transaction kinds
    localparam logic [KIND_W-1:0] KIND_QUAD_SAMPLE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CLICK_SAMPLE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DELTA_READ   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CLICK_READ   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_QUAD_PRIME   = 3'd4;

    // Gray states and reset values
    localparam logic [1:0] QUAD_00 = 2'b00;
    localparam logic [1:0] QUAD_01 = 2'b01;
    localparam logic [1:0] QUAD_11 = 2'b11;
    localparam logic [1:0] QUAD_10 = 2'b10;
    localparam logic [1:0] QUAD_RESET = QUAD_11;
    localparam logic [TH_W-1:0] THRESHOLD_RESET = 8'd4;

    // Step codes
    localparam logic signed [STEP_W-1:0] STEP_NONE   = 2'sb00;
    localparam logic signed [STEP_W-1:0] STEP_FWD    = 2'sb01;
    localparam logic signed [STEP_W-1:0] STEP_REV    = 2'sb11;
    localparam logic signed [STEP_W-1:0] STEP_UNUSED = 2'sb10;

    // Per-lane command, already qualified by the accepted transaction
    typedef struct packed {
        logic quad_load;
        logic count_en;
        logic click_load;
        logic delta_read;
    } lane_cmd_t;

    // Per-lane report toward the merge stage
    typedef struct packed {
        logic fire;
        logic neg;
        logic edge_flag;
    } lane_stat_t;

    // Forward Gray successor: 00->01->11->10->00
    function automatic logic [1:0] gray_next(input logic [1:0] q);
        logic [1:0] r;
        begin
            case (q)
                QUAD_00: r = QUAD_01;
                QUAD_01: r = QUAD_11;
                QUAD_11: r = QUAD_10;
                QUAD_10: r = QUAD_00;
                default: r = QUAD_00;
            endcase
            return r;
        end
    endfunction

endpackage

// File: rtl/mqe_lane.sv
// One encoder lane: Gray decode, saturating count, click edge and detent check.
module mqe_lane
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  mqe_pkg::lane_cmd_t            cmd,
    input  logic                          pin_a,
    input  logic                          pin_b,
    input  logic                          click_level,
    input  logic                          sel,
    input  logic [mqe_pkg::TH_W-1:0]      threshold,
    output mqe_pkg::lane_stat_t           stat
);

    localparam int MAG_W = mqe_pkg::COUNT_W + 1;
    localparam logic signed [mqe_pkg::COUNT_W-1:0] COUNT_MAX =
        {1'b0, {(mqe_pkg::COUNT_W-1){1'b1}}};
    localparam logic signed [mqe_pkg::COUNT_W-1:0] COUNT_MIN =
        {1'b1, {(mqe_pkg::COUNT_W-1){1'b0}}};

    logic [1:0]                          prev_quad_reg, prev_quad_next;
    logic signed [mqe_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic                                click_before_reg, click_before_next;
    logic                                click_edge_reg, click_edge_next;

    logic [1:0]       quad_now;
    logic             dir_up, dir_dn, pressed, fire;
    logic [MAG_W-1:0] mag;

    // Decode direction against the stored state
    assign quad_now = {pin_a, pin_b};
    assign dir_up   = (mqe_pkg::gray_next(prev_quad_reg) == quad_now);
    assign dir_dn   = (mqe_pkg::gray_next(quad_now) == prev_quad_reg);
    assign pressed  = ~click_level;

    // Count magnitude against the detent threshold
    assign mag  = count_reg[mqe_pkg::COUNT_W-1]
                ? (MAG_W'(~count_reg) + MAG_W'(1))
                : MAG_W'(count_reg);
    assign fire = sel & (mag >= MAG_W'(threshold));

    assign stat.fire      = fire;
    assign stat.neg       = count_reg[mqe_pkg::COUNT_W-1];
    assign stat.edge_flag = sel & click_edge_reg;

    // Next state of the lane
    always_comb
    begin
        prev_quad_next    = prev_quad_reg;
        count_next        = count_reg;
        click_before_next = click_before_reg;
        click_edge_next   = click_edge_reg;
        if (cmd.quad_load)
        begin
            prev_quad_next = quad_now;
        end
        if (cmd.count_en)
        begin
            if (dir_up && (count_reg != COUNT_MAX))
            begin
                count_next = count_reg + 16'sd1;
            end
            else if (dir_dn && (count_reg != COUNT_MIN))
            begin
                count_next = count_reg - 16'sd1;
            end
        end
        if (cmd.click_load)
        begin
            click_edge_next   = pressed & ~click_before_reg;
            click_before_next = pressed;
        end
        if (cmd.delta_read && fire)
        begin
            count_next = '0;
        end
    end

    // Hold lane state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_quad_reg    <= mqe_pkg::QUAD_RESET;
            count_reg        <= '0;
            click_before_reg <= 1'b0;
            click_edge_reg   <= 1'b0;
        end
        else
        begin
            prev_quad_reg    <= prev_quad_next;
            count_reg        <= count_next;
            click_before_reg <= click_before_next;
            click_edge_reg   <= click_edge_next;
        end
    end

endmodule

// File: rtl/mqe_merge.sv
// Merge stage: combine lane reports into one result and hold it in the output register.
module mqe_merge
#(
    parameter int NUM_ENCODERS = mqe_pkg::NUM_ENCODERS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  mqe_pkg::lane_stat_t               stats [NUM_ENCODERS],
    input  logic                              load,
    input  logic                              is_delta,
    input  logic                              is_click,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic signed [mqe_pkg::STEP_W-1:0] step,
    output logic                              click_event
);

    logic                              out_valid_reg, out_valid_next;
    logic signed [mqe_pkg::STEP_W-1:0] step_reg, step_next;
    logic                              click_reg, click_next;
    logic                              any_fire, any_neg, any_edge;

    // Reduce the lane reports; at most one lane is selected
    always_comb
    begin
        any_fire = 1'b0;
        any_neg  = 1'b0;
        any_edge = 1'b0;
        for (int i = 0; i < NUM_ENCODERS; i++)
        begin
            any_fire = any_fire | stats[i].fire;
            any_neg  = any_neg  | (stats[i].fire & stats[i].neg);
            any_edge = any_edge | stats[i].edge_flag;
        end
    end

    // Form the result of the accepted transaction
    always_comb
    begin
        step_next  = mqe_pkg::STEP_NONE;
        click_next = is_click & any_edge;
        if (is_delta && any_fire)
        begin
            step_next = any_neg ? mqe_pkg::STEP_REV : mqe_pkg::STEP_FWD;
        end
        out_valid_next = load | (out_valid_reg & ~out_ready);
    end

    // Hold the output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load payload on acceptance
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            step_reg  <= step_next;
            click_reg <= click_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign step        = step_reg;
    assign click_event = click_reg;

endmodule

// File: rtl/multi_quadrature_encoder_core.sv
// Top level of the quadrature encoder bank: lanes, merge stage and threshold register.
//
//  Channel  Direction  Handshake            Payload
//  in       sink       in_valid/in_ready    kind, pins_a, pins_b, click_levels, index
//  out      source     out_valid/out_ready  step, click_event
//  cfg      sink       cfg_valid/cfg_ready  cfg_data (detent threshold)
//
// One transaction per cycle while in_ready is high; its result appears the cycle after.
// Encoder lanes update in the accept cycle; the output register sets the latency.
// A stalled output holds its result; in_ready stays high while out is empty or taken.
// Reset (rst_n low) sets every lane to state 11, count 0, clicks clear, threshold 4.
// cfg_ready is always high.
module multi_quadrature_encoder_core
#(
    parameter int NUM_ENCODERS = mqe_pkg::NUM_ENCODERS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [mqe_pkg::KIND_W-1:0]         kind,
    input  logic [mqe_pkg::PIN_W-1:0]          pins_a,
    input  logic [mqe_pkg::PIN_W-1:0]          pins_b,
    input  logic [mqe_pkg::PIN_W-1:0]          click_levels,
    input  logic [mqe_pkg::INDEX_W-1:0]        index,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [mqe_pkg::STEP_W-1:0]  step,
    output logic                               click_event,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mqe_pkg::TH_W-1:0]           cfg_data
);

    logic [mqe_pkg::TH_W-1:0] threshold_reg, threshold_next;
    logic [mqe_pkg::TH_W-1:0] threshold_eff;
    logic                     accept, is_quad, is_prime, is_click_smp, is_delta, is_click;
    mqe_pkg::lane_cmd_t       cmd;
    mqe_pkg::lane_stat_t      stats [NUM_ENCODERS];

    // Handshakes
    assign in_ready  = ~out_valid | out_ready;
    assign accept    = in_valid & in_ready;
    assign cfg_ready = 1'b1;

    // Threshold register; zero acts as one
    assign threshold_next = (cfg_valid && cfg_ready) ? cfg_data : threshold_reg;
    assign threshold_eff  = (threshold_reg == '0) ? mqe_pkg::TH_W'(1) : threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= mqe_pkg::THRESHOLD_RESET;
        end
        else
        begin
            threshold_reg <= threshold_next;
        end
    end

    // Decode the transaction kind
    assign is_quad      = (kind == mqe_pkg::KIND_QUAD_SAMPLE);
    assign is_prime     = (kind == mqe_pkg::KIND_QUAD_PRIME);
    assign is_click_smp = (kind == mqe_pkg::KIND_CLICK_SAMPLE);
    assign is_delta     = (kind == mqe_pkg::KIND_DELTA_READ);
    assign is_click     = (kind == mqe_pkg::KIND_CLICK_READ);

    assign cmd.quad_load  = accept & (is_quad | is_prime);
    assign cmd.count_en   = accept & is_quad;
    assign cmd.click_load = accept & is_click_smp;
    assign cmd.delta_read = accept & is_delta;

    // Encoder lanes
    for (genvar i = 0; i < NUM_ENCODERS; i++)
    begin : g_lane
        logic lane_a, lane_b, lane_click, lane_sel;

        if (i < mqe_pkg::PIN_W)
        begin : g_pins
            assign lane_a     = pins_a[i];
            assign lane_b     = pins_b[i];
            assign lane_click = click_levels[i];
        end
        else
        begin : g_nopins
            assign lane_a     = 1'b0;
            assign lane_b     = 1'b0;
            assign lane_click = 1'b0;
        end

        assign lane_sel = (index == mqe_pkg::INDEX_W'(i));

        mqe_lane u_lane
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .pin_a       (lane_a),
            .pin_b       (lane_b),
            .click_level (lane_click),
            .sel         (lane_sel),
            .threshold   (threshold_eff),
            .stat        (stats[i])
        );
    end

    // Merge and output register
    mqe_merge #(
        .NUM_ENCODERS (NUM_ENCODERS)
    ) u_merge
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .stats       (stats),
        .load        (accept),
        .is_delta    (is_delta),
        .is_click    (is_click),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .step        (step),
        .click_event (click_event)
    );

endmodule

// File: rtl/mqe_checker.sv
// Port-level checker for the encoder bank and its bind to the top level.
module mqe_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic [mqe_pkg::KIND_W-1:0]        kind,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [mqe_pkg::STEP_W-1:0] step,
    input logic                              click_event
);

    // Every accepted transaction yields a result next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("no result after accepted transaction");

    // Only a delta read may report a step
    a_step_only_delta: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind != mqe_pkg::KIND_DELTA_READ)
        |=> step == mqe_pkg::STEP_NONE)
        else $error("step on a non delta transaction");

    // Only a click read may report a click
    a_click_only_read: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind != mqe_pkg::KIND_CLICK_READ) |=> !click_event)
        else $error("click event on a non click read");

    // A step is never the unused code
    a_step_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (step != mqe_pkg::STEP_UNUSED))
        else $error("illegal step code");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(step) && $stable(click_event))
        else $error("stalled result changed");

endmodule

bind multi_quadrature_encoder_core mqe_checker u_mqe_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .step        (step),
    .click_event (click_event)
);

// File: test/tb_multi_quadrature_encoder_core.sv
// Self-checking testbench of the quadrature encoder bank core.
`timescale 1ns / 100ps

module tb_multi_quadrature_encoder_core;

    localparam int LANES      = mqe_pkg::NUM_ENCODERS_DEF;
    localparam int IDLE_LIMIT = 2000;

    typedef struct packed {
        logic [mqe_pkg::KIND_W-1:0]  kind;
        logic [mqe_pkg::PIN_W-1:0]   pa;
        logic [mqe_pkg::PIN_W-1:0]   pb;
        logic [mqe_pkg::PIN_W-1:0]   levels;
        logic [mqe_pkg::INDEX_W-1:0] idx;
    } enc_item_t;

    typedef struct packed {
        logic signed [mqe_pkg::STEP_W-1:0] step;
        logic                              click;
    } enc_report_t;

    logic                                clk;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    logic [mqe_pkg::KIND_W-1:0]          kind = '0;
    logic [mqe_pkg::PIN_W-1:0]           pins_a = '0;
    logic [mqe_pkg::PIN_W-1:0]           pins_b = '0;
    logic [mqe_pkg::PIN_W-1:0]           click_levels = '1;
    logic [mqe_pkg::INDEX_W-1:0]         index = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic signed [mqe_pkg::STEP_W-1:0]   step;
    logic                                click_event;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [mqe_pkg::TH_W-1:0]            cfg_data = '0;

    // Predicted bank state
    logic [mqe_pkg::TH_W-1:0]            detent_thr = mqe_pkg::THRESHOLD_RESET;
    logic [1:0]                          lane_quad [LANES];
    logic signed [mqe_pkg::COUNT_W-1:0]  lane_count [LANES];
    logic                                lane_pressed [LANES];
    logic                                lane_press_edge [LANES];

    // Pin state that the stimulus generator walks from
    logic [1:0]                          walk_quad [LANES];

    enc_item_t                           queued_transactions [$];
    enc_report_t                         expected_reports [$];
    enc_item_t                           presented;
    int                                  burst_left = 0;
    int                                  gap_left = 0;
    int                                  stall_tick = 0;
    int                                  stall_mode = 0;
    int                                  quiet_cycles = 0;
    int                                  error_count = 0;

    multi_quadrature_encoder_core DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .pins_a       (pins_a),
        .pins_b       (pins_b),
        .click_levels (click_levels),
        .index        (index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .step         (step),
        .click_event  (click_event),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Forward Gray successor of a 2-bit A/B state
    function automatic logic [1:0] gray_succ(input logic [1:0] q);
        logic [1:0] r;
        case (q)
            mqe_pkg::QUAD_00: r = mqe_pkg::QUAD_01;
            mqe_pkg::QUAD_01: r = mqe_pkg::QUAD_11;
            mqe_pkg::QUAD_11: r = mqe_pkg::QUAD_10;
            default:          r = mqe_pkg::QUAD_00;
        endcase
        return r;
    endfunction

    // Apply one lane move: 1 forward, -1 reverse, 2 double jump, 0 hold
    function automatic logic [1:0] lane_move(input logic [1:0] q, input int m);
        logic [1:0] r;
        case (m)
            1:       r = gray_succ(q);
            -1:      r = gray_succ(gray_succ(gray_succ(q)));
            2:       r = gray_succ(gray_succ(q));
            default: r = q;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Advance the predicted bank by one transaction and queue its report
    task automatic predict_encoder_bank(input enc_item_t it);
        enc_report_t          r;
        logic [1:0]           q;
        logic signed [16:0]   c;
        int                   mag;
        int                   th;
        logic                 now_pressed;
        r.step  = mqe_pkg::STEP_NONE;
        r.click = 1'b0;
        case (it.kind)
            mqe_pkg::KIND_QUAD_SAMPLE, mqe_pkg::KIND_QUAD_PRIME:
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    q = (l < mqe_pkg::PIN_W) ? {it.pa[l], it.pb[l]} : mqe_pkg::QUAD_00;
                    if (it.kind == mqe_pkg::KIND_QUAD_SAMPLE)
                    begin
                        c = lane_count[l];
                        if (gray_succ(lane_quad[l]) == q)
                            c = c + 17'sd1;
                        else if (gray_succ(q) == lane_quad[l])
                            c = c - 17'sd1;
                        if (c > 17'sd32767)
                            c = 17'sd32767;
                        if (c < -17'sd32768)
                            c = -17'sd32768;
                        lane_count[l] = c[mqe_pkg::COUNT_W-1:0];
                    end
                    lane_quad[l] = q;
                end
            end
            mqe_pkg::KIND_CLICK_SAMPLE:
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    now_pressed = (l < mqe_pkg::PIN_W) ? ~it.levels[l] : 1'b1;
                    lane_press_edge[l] = now_pressed & ~lane_pressed[l];
                    lane_pressed[l] = now_pressed;
                end
            end
            mqe_pkg::KIND_DELTA_READ:
            begin
                if (it.idx < LANES)
                begin
                    th  = (detent_thr == 0) ? 1 : int'(detent_thr);
                    mag = (lane_count[it.idx] < 0) ? -int'(lane_count[it.idx])
                                                   : int'(lane_count[it.idx]);
                    if (mag >= th)
                    begin
                        r.step = (lane_count[it.idx] > 0) ? mqe_pkg::STEP_FWD
                                                          : mqe_pkg::STEP_REV;
                        lane_count[it.idx] = '0;
                    end
                end
            end
            mqe_pkg::KIND_CLICK_READ:
            begin
                if (it.idx < LANES)
                    r.click = lane_press_edge[it.idx];
            end
            default:
            begin
            end
        endcase
        expected_reports.push_back(r);
    endtask

    task automatic add_item(input logic [mqe_pkg::KIND_W-1:0] k,
                            input logic [mqe_pkg::PIN_W-1:0] a,
                            input logic [mqe_pkg::PIN_W-1:0] b,
                            input logic [mqe_pkg::PIN_W-1:0] lv,
                            input logic [mqe_pkg::INDEX_W-1:0] ix);
        enc_item_t it;
        it.kind   = k;
        it.pa     = a;
        it.pb     = b;
        it.levels = lv;
        it.idx    = ix;
        if (k == mqe_pkg::KIND_QUAD_SAMPLE || k == mqe_pkg::KIND_QUAD_PRIME)
            for (int l = 0; l < LANES; l++)
                walk_quad[l] = (l < mqe_pkg::PIN_W) ? {a[l], b[l]} : mqe_pkg::QUAD_00;
        queued_transactions.push_back(it);
    endtask

    // Quad sample built from the walked lane states
    task automatic add_walk_sample();
        logic [mqe_pkg::PIN_W-1:0] a;
        logic [mqe_pkg::PIN_W-1:0] b;
        a = '0;
        b = '0;
        for (int l = 0; l < LANES && l < mqe_pkg::PIN_W; l++)
        begin
            a[l] = walk_quad[l][1];
            b[l] = walk_quad[l][0];
        end
        add_item(mqe_pkg::KIND_QUAD_SAMPLE, a, b, mqe_pkg::PIN_W'($urandom),
                 mqe_pkg::INDEX_W'($urandom));
    endtask

    function automatic logic [mqe_pkg::INDEX_W-1:0] pick_index();
        if ($urandom_range(0, 4) == 0)
            return mqe_pkg::INDEX_W'($urandom_range(0, 15));
        return mqe_pkg::INDEX_W'($urandom_range(0, LANES - 1));
    endfunction

    // Hold until every queued transaction is accepted and every report is back;
    // look between edges so that the driver's updates have settled
    task automatic wait_drained();
        @(negedge clk);
        while (queued_transactions.size() != 0 || in_valid || expected_reports.size() != 0)
            @(negedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [mqe_pkg::TH_W-1:0] v);
        wait_drained();
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        detent_thr = v;
        cfg_valid <= 1'b0;
    endtask

    // Runs of mostly clean Gray steps per lane, closed by delta reads
    task automatic random_phase(input int budget);
        int done;
        int n;
        int r;
        int th;
        int m;
        int dirs [LANES];
        done = 0;
        while (done < budget)
        begin
            th = (detent_thr == 0) ? 1 : int'(detent_thr);
            n  = $urandom_range(th / 2 + 1, 2 * th + 8);
            for (int l = 0; l < LANES; l++)
                dirs[l] = $urandom_range(0, 1) ? 1 : -1;
            for (int k = 0; k < n && done < budget; k++)
            begin
                r = $urandom_range(0, 39);
                if (r == 0)
                    add_item(mqe_pkg::KIND_W'($urandom_range(0, 7)),
                             mqe_pkg::PIN_W'($urandom), mqe_pkg::PIN_W'($urandom),
                             mqe_pkg::PIN_W'($urandom), mqe_pkg::INDEX_W'($urandom));
                else if (r == 1)
                    add_item(mqe_pkg::KIND_CLICK_SAMPLE, mqe_pkg::PIN_W'($urandom),
                             mqe_pkg::PIN_W'($urandom), mqe_pkg::PIN_W'($urandom),
                             mqe_pkg::INDEX_W'($urandom));
                else if (r == 2)
                    add_item(mqe_pkg::KIND_CLICK_READ, mqe_pkg::PIN_W'($urandom),
                             mqe_pkg::PIN_W'($urandom), mqe_pkg::PIN_W'($urandom),
                             pick_index());
                else if (r == 3)
                    add_item(mqe_pkg::KIND_QUAD_PRIME, mqe_pkg::PIN_W'($urandom),
                             mqe_pkg::PIN_W'($urandom), mqe_pkg::PIN_W'($urandom),
                             mqe_pkg::INDEX_W'($urandom));
                else
                begin
                    for (int l = 0; l < LANES; l++)
                    begin
                        r = $urandom_range(0, 99);
                        if (r < 90)
                            m = dirs[l];
                        else if (r < 94)
                            m = 0;
                        else if (r < 97)
                            m = 2;
                        else
                            m = -dirs[l];
                        walk_quad[l] = lane_move(walk_quad[l], m);
                    end
                    add_walk_sample();
                end
                done++;
            end
            r = $urandom_range(1, 6);
            for (int k = 0; k < r; k++)
                add_item(mqe_pkg::KIND_DELTA_READ, mqe_pkg::PIN_W'($urandom),
                         mqe_pkg::PIN_W'($urandom), mqe_pkg::PIN_W'($urandom),
                         pick_index());
            done += r;
        end
    endtask

    // Reset, stimulus phases and final verdict
    initial
    begin
        for (int l = 0; l < LANES; l++)
        begin
            lane_quad[l]       = mqe_pkg::QUAD_RESET;
            lane_count[l]      = '0;
            lane_pressed[l]    = 1'b0;
            lane_press_edge[l] = 1'b0;
            walk_quad[l]       = mqe_pkg::QUAD_RESET;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reads at reset, one lane of each move kind, detent and clear
        add_item(mqe_pkg::KIND_DELTA_READ, '0, '0, '1, 4'd0);
        add_item(mqe_pkg::KIND_CLICK_READ, '0, '0, '1, 4'd0);
        add_item(mqe_pkg::KIND_QUAD_SAMPLE, 4'b1111, 4'b1111, '1, 4'd0);
        add_item(mqe_pkg::KIND_QUAD_SAMPLE, 4'b1001, 4'b1010, '1, 4'd0);
        add_item(mqe_pkg::KIND_QUAD_SAMPLE, 4'b1000, 4'b1010, '1, 4'd0);
        add_item(mqe_pkg::KIND_QUAD_SAMPLE, 4'b1000, 4'b1011, '1, 4'd0);
        add_item(mqe_pkg::KIND_QUAD_SAMPLE, 4'b1001, 4'b1011, '1, 4'd0);
        add_item(mqe_pkg::KIND_DELTA_READ, '1, '1, '0, 4'd0);
        add_item(mqe_pkg::KIND_DELTA_READ, '0, '0, '1, 4'd0);
        add_item(mqe_pkg::KIND_DELTA_READ, '0, '0, '1, 4'd1);
        // Prime without counting, then one full reverse cycle on all lanes
        add_item(mqe_pkg::KIND_QUAD_PRIME, 4'b0000, 4'b0000, '1, 4'd0);
        add_item(mqe_pkg::KIND_QUAD_SAMPLE, 4'b1111, 4'b0000, '1, 4'd0);
        add_item(mqe_pkg::KIND_QUAD_SAMPLE, 4'b1111, 4'b1111, '1, 4'd0);
        add_item(mqe_pkg::KIND_QUAD_SAMPLE, 4'b0000, 4'b1111, '1, 4'd0);
        add_item(mqe_pkg::KIND_QUAD_SAMPLE, 4'b0000, 4'b0000, '1, 4'd0);
        add_item(mqe_pkg::KIND_DELTA_READ, '0, '0, '1, 4'd2);
        add_item(mqe_pkg::KIND_DELTA_READ, '0, '0, '1, 4'd15);
        add_item(mqe_pkg::KIND_DELTA_READ, '0, '0, '1, 4'd4);
        // Press edges, sticky across reads, out-of-range click read
        add_item(mqe_pkg::KIND_CLICK_SAMPLE, '0, '0, 4'b1111, 4'd0);
        add_item(mqe_pkg::KIND_CLICK_SAMPLE, '0, '0, 4'b0101, 4'd0);
        add_item(mqe_pkg::KIND_CLICK_READ, '0, '0, '1, 4'd1);
        add_item(mqe_pkg::KIND_CLICK_READ, '0, '0, '1, 4'd1);
        add_item(mqe_pkg::KIND_CLICK_READ, '0, '0, '1, 4'd9);
        add_item(mqe_pkg::KIND_CLICK_SAMPLE, '0, '0, 4'b0000, 4'd0);
        add_item(mqe_pkg::KIND_CLICK_READ, '0, '0, '1, 4'd3);
        // Unused kinds
        add_item(3'd5, '1, '1, '0, '1);
        add_item(3'd6, '1, '1, '0, '1);
        add_item(3'd7, '1, '1, '0, '1);

        write_threshold(8'd1);
        random_phase(80);
        write_threshold(8'd255);
        random_phase(500);
        write_threshold(8'd0);
        random_phase(80);
        write_threshold(mqe_pkg::TH_W'($urandom_range(2, 16)));
        random_phase(80);
        write_threshold(mqe_pkg::TH_W'($urandom_range(17, 254)));
        random_phase(80);
        wait_drained();

        if (expected_reports.size() != 0)
            report_mismatch("reports never returned", 0, expected_reports.size());
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Present queued transactions in bursts with random gaps
    always @(posedge clk)
    begin
        logic load;
        load = 1'b0;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predict_encoder_bank(presented);
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (queued_transactions.size() > 0)
                begin
                    presented = queued_transactions.pop_front();
                    load = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                                 : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end
                in_valid <= load;
                if (load)
                begin
                    kind         <= presented.kind;
                    pins_a       <= presented.pa;
                    pins_b       <= presented.pb;
                    click_levels <= presented.levels;
                    index        <= presented.idx;
                end
            end
        end
    end

    // Check each result transaction and stall the output on a shifting pattern
    always @(posedge clk)
    begin
        enc_report_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                    report_mismatch("result with none expected", int'(step), 0);
                else
                begin
                    want = expected_reports.pop_front();
                    if (step !== want.step)
                        report_mismatch("step", int'(step), int'(want.step));
                    if (click_event !== want.click)
                        report_mismatch("click_event", int'(click_event), int'(want.click));
                end
            end
            stall_tick++;
            if (stall_tick % 97 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom_range(0, 1));
                2:       out_ready <= (stall_tick % 4 == 0);
                default: out_ready <= ($urandom_range(0, 7) == 0) || (stall_tick % 16 == 0);
            endcase
        end
    end

    // End the run when no channel has moved for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule

// File: files.f
rtl/mqe_pkg.sv
rtl/mqe_lane.sv
rtl/mqe_merge.sv
rtl/multi_quadrature_encoder_core.sv
rtl/mqe_checker.sv
test/tb_multi_quadrature_encoder_core.sv
